@@ rtl/tdpt_pkg.sv @@
// Package for the trial-division prime tester: microcode types, program ROM and defaults.
package tdpt_pkg;

    // Default width of the tested value
    localparam int VALUE_WIDTH_DEF = 14;

    // Step counter of the sequencer
    typedef logic [2:0] t_upc;

    localparam t_upc STEP_ACCEPT = 3'd0;
    localparam t_upc STEP_LOW    = 3'd1;
    localparam t_upc STEP_BOUND  = 3'd2;
    localparam t_upc STEP_DIV    = 3'd3;
    localparam t_upc STEP_TEST   = 3'd4;
    localparam t_upc STEP_EMIT   = 3'd5;

    // Datapath operation selected by a control word
    typedef enum logic [2:0] {
        U_ACCEPT,    // take a new word, set divisor to 2 and its square to 4
        U_CHK_LOW,   // clear the prime flag for 0 and 1
        U_DIV_INIT,  // load the dividend shifter, clear the remainder
        U_DIV_STEP,  // one restoring division bit
        U_TEST,      // check remainder, advance divisor and square
        U_EMIT       // load the output register
    } t_uop;

    // Jump condition of a control word
    typedef enum logic [2:0] {
        C_IN_VALID,
        C_LOW,
        C_SQ_OVER,
        C_DIV_DONE,
        C_REM_ZERO,
        C_OUT_FREE
    } t_cond;

    typedef struct packed {
        t_uop  op;
        t_cond cond;
        t_upc  jump;   // taken when the condition holds
        t_upc  next;   // taken otherwise
    } t_uword;

    // Program ROM
    function automatic t_uword ucode_rom(t_upc addr);
        t_uword w;
        unique case (addr)
            STEP_ACCEPT: w = '{U_ACCEPT,   C_IN_VALID, STEP_LOW,   STEP_ACCEPT};
            STEP_LOW:    w = '{U_CHK_LOW,  C_LOW,      STEP_EMIT,  STEP_BOUND};
            STEP_BOUND:  w = '{U_DIV_INIT, C_SQ_OVER,  STEP_EMIT,  STEP_DIV};
            STEP_DIV:    w = '{U_DIV_STEP, C_DIV_DONE, STEP_TEST,  STEP_DIV};
            STEP_TEST:   w = '{U_TEST,     C_REM_ZERO, STEP_EMIT,  STEP_BOUND};
            STEP_EMIT:   w = '{U_EMIT,     C_OUT_FREE, STEP_ACCEPT, STEP_EMIT};
            default:     w = '{U_EMIT,     C_OUT_FREE, STEP_ACCEPT, STEP_ACCEPT};
        endcase
        return w;
    endfunction

endpackage

@@ rtl/trial_division_prime_test.sv @@
// Trial-division prime tester driven by a microcoded sequencer with a bit-serial divider.
// Steps per word: accept, then the low check, going to emit for values below 2; else, for
// each trial divisor, the bound check (to emit once its square exceeds the value), the
// bit-serial division and the remainder test (to emit when the divisor divides the value).
// Throughput: one word at a time; the next word is taken once the result sits in the
// output register, which holds it until the sink takes it.
// Reset: i_rst_n, synchronous, active low; returns to the accept step with no result pending.
module trial_division_prime_test #(
    parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // slave side: tdata = value
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]     i_s_tdata,
    // master side: tdata = tested_value, is_prime, zero fill
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [((VALUE_WIDTH+8)/8)*8-1:0]     o_m_tdata
);

    localparam int DW   = VALUE_WIDTH / 2 + 1;       // divisor width
    localparam int SW   = 2 * DW;                    // divisor square width
    localparam int CW   = $clog2(VALUE_WIDTH + 1);   // division bit counter width
    localparam int OTW  = ((VALUE_WIDTH + 8) / 8) * 8;

    // Sequencer
    tdpt_pkg::t_upc   r_upc, n_upc;
    tdpt_pkg::t_uword w_uw;
    logic             w_cond;

    // Datapath registers
    logic [VALUE_WIDTH-1:0] r_val;
    logic [VALUE_WIDTH-1:0] r_dvd, n_dvd;
    logic [DW-1:0]          r_div, n_div;
    logic [SW-1:0]          r_sq, n_sq;
    logic [DW-1:0]          r_rem, n_rem;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_prime, n_prime;

    // Output register
    logic                   r_out_valid, n_out_valid;
    logic [VALUE_WIDTH-1:0] r_out_value;
    logic                   r_out_prime;
    logic                   w_out_free;
    logic                   w_load_out;

    // Division bit
    logic [DW:0]            w_trial;
    logic                   w_ge;

    assign w_uw       = tdpt_pkg::ucode_rom(r_upc);
    assign w_out_free = !r_out_valid || i_m_tready;

    assign w_trial = {r_rem, r_dvd[VALUE_WIDTH-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};

    // Condition select
    always_comb begin
        unique case (w_uw.cond)
            tdpt_pkg::C_IN_VALID: w_cond = i_s_tvalid;
            tdpt_pkg::C_LOW:      w_cond = r_val < VALUE_WIDTH'(2);
            tdpt_pkg::C_SQ_OVER:  w_cond = r_sq > SW'(r_val);
            tdpt_pkg::C_DIV_DONE: w_cond = r_cnt == CW'(1);
            tdpt_pkg::C_REM_ZERO: w_cond = r_rem == '0;
            tdpt_pkg::C_OUT_FREE: w_cond = w_out_free;
            default:              w_cond = 1'b0;
        endcase
    end

    // Control word decode and datapath next values
    always_comb begin
        n_upc       = w_cond ? w_uw.jump : w_uw.next;
        n_dvd       = r_dvd;
        n_div       = r_div;
        n_sq        = r_sq;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_prime     = r_prime;
        o_s_tready  = 1'b0;
        w_load_out  = 1'b0;
        unique case (w_uw.op)
            tdpt_pkg::U_ACCEPT: begin
                o_s_tready = 1'b1;
                n_div      = DW'(2);
                n_sq       = SW'(4);
                n_prime    = 1'b1;
            end
            tdpt_pkg::U_CHK_LOW: begin
                n_prime = !w_cond;
            end
            tdpt_pkg::U_DIV_INIT: begin
                n_dvd = r_val;
                n_rem = '0;
                n_cnt = CW'(VALUE_WIDTH);
            end
            tdpt_pkg::U_DIV_STEP: begin
                n_rem = w_ge ? DW'(w_trial - {1'b0, r_div}) : DW'(w_trial);
                n_dvd = {r_dvd[VALUE_WIDTH-2:0], 1'b0};
                n_cnt = r_cnt - CW'(1);
            end
            tdpt_pkg::U_TEST: begin
                if (w_cond) begin
                    n_prime = 1'b0;
                end else begin
                    // (d+1)^2 = d^2 + 2d + 1
                    n_sq  = r_sq + SW'({r_div, 1'b1});
                    n_div = r_div + DW'(1);
                end
            end
            tdpt_pkg::U_EMIT: begin
                w_load_out = w_out_free;
            end
            default: begin
                n_upc = tdpt_pkg::STEP_ACCEPT;
            end
        endcase
    end

    // Output valid next value
    always_comb begin
        n_out_valid = r_out_valid;
        if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= tdpt_pkg::STEP_ACCEPT;
            r_out_valid <= 1'b0;
        end else begin
            r_upc       <= n_upc;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_dvd   <= n_dvd;
        r_div   <= n_div;
        r_sq    <= n_sq;
        r_rem   <= n_rem;
        r_cnt   <= n_cnt;
        r_prime <= n_prime;
        if (o_s_tready && i_s_tvalid) begin
            r_val <= i_s_tdata[VALUE_WIDTH-1:0];
        end
        if (w_load_out) begin
            r_out_value <= r_val;
            r_out_prime <= r_prime;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OTW'({r_out_prime, r_out_value});

    // Values below two never leave flagged prime
    a_low_not_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_value < VALUE_WIDTH'(2)) |-> !r_out_prime)
        else $error("value below two reported prime");

    // Divisor is at least two while a word is in work
    a_div_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc != tdpt_pkg::STEP_ACCEPT) |-> (r_div >= DW'(2)))
        else $error("trial divisor below two");

    // Partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == tdpt_pkg::STEP_DIV || r_upc == tdpt_pkg::STEP_TEST) |-> (r_rem < r_div))
        else $error("remainder not below divisor");

    // A pending result is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> $stable(r_out_value) && $stable(r_out_prime))
        else $error("pending result overwritten");

endmodule
